>>> hdl/cwh_pkg.sv
// shared types, codes and constants for the case-insensitive word hash set
`timescale 1ns / 1ps
package cwh_pkg;

	localparam int CHAR_W      = 8;
	localparam int LEN_W       = 6;
	localparam int COUNT_OUT_W = 13;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POOL_FULL = 2'd1;
	localparam logic [1:0] ST_TOO_LONG  = 2'd2;

	localparam logic [6:0]  HASH_MUL = 7'd113;
	localparam logic [23:0] HASH_MOD = 24'd10000007;
	// floor(2^40 / HASH_MOD)
	localparam logic [16:0] HASH_RCP = 17'd109951;

	typedef struct packed {
		logic [1:0]        kind;
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic                   found;
		logic [1:0]             status;
		logic [COUNT_OUT_W-1:0] word_count;
	} out_item_t;

	typedef enum logic [2:0] {
		FS_IDLE, FS_MUL, FS_RCP, FS_RED, FS_BMUL, FS_BRED, FS_PUSH
	} fstate_t;

	typedef enum logic [2:0] {
		BS_INIT, BS_IDLE, BS_HEAD, BS_HCHK, BS_TAIL, BS_CMP, BS_CLEAR
	} bstate_t;

	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

endpackage

>>> hdl/case_insensitive_word_hash_set.sv
// top level of the case-insensitive word hash set
`timescale 1ns / 1ps
// Usage: words arrive one byte per transfer on item (kind, char_code, last).
// A transfer takes place when start is high and busy is low. The byte with
// last set ends the word; its kind picks insert or lookup. Kind clear
// empties the table, kind 3 is dropped with no effect.
// One result per word end and per clear comes out on result for exactly one
// cycle with done high; the receiver cannot stall it and must take it then.
// Each byte within MAX_WORD_LEN passes the three-step hash multiply and
// modulo reduction before the next byte is taken, busy staying high; a
// word end adds the bucket reduction (not for an overlong word) and the
// queue push, and waits longer while the queue is full. After the queue,
// an insert or lookup reads its bucket head and walks the chain one entry
// at a time unless refused as overlong or for a full pool; a clear sweeps
// the bucket heads one per cycle. Reset: busy stays high after reset while
// the bucket heads are swept to empty; the entry pool needs no clearing.
module case_insensitive_word_hash_set #(
	parameter int BUCKETS      = 1024,
	parameter int MAX_WORD_LEN = 45,
	parameter int POOL_ENTRIES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cwh_pkg::in_item_t   item,
	output logic                done,
	output cwh_pkg::out_item_t  result
);
	import cwh_pkg::*;

	localparam int BKT_W  = $clog2(BUCKETS);
	localparam int TEXT_W = MAX_WORD_LEN * 8;
	localparam int CMD_W  = 2 + 1 + LEN_W + BKT_W + TEXT_W;

	logic              push, full, q_valid, pop, init;
	logic [1:0]        f_kind, b_kind;
	logic              f_ovl, b_ovl;
	logic [LEN_W-1:0]  f_len, b_len;
	logic [BKT_W-1:0]  f_bkt, b_bkt;
	logic [TEXT_W-1:0] f_text, b_text;
	logic [CMD_W-1:0]  q_din, q_dout;

	cwh_front #(.BUCKETS(BUCKETS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .hold(init), .item(item),
		.busy(busy), .push(push), .full(full),
		.cmd_kind(f_kind), .cmd_ovl(f_ovl), .cmd_len(f_len),
		.cmd_bucket(f_bkt), .cmd_text(f_text)
	);

	assign q_din = {f_kind, f_ovl, f_len, f_bkt, f_text};

	cwh_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(q_din), .full(full),
		.pop(pop), .valid(q_valid), .dout(q_dout)
	);

	assign {b_kind, b_ovl, b_len, b_bkt, b_text} = q_dout;

	cwh_back #(
		.BUCKETS(BUCKETS), .MAX_WORD_LEN(MAX_WORD_LEN), .POOL_ENTRIES(POOL_ENTRIES)
	) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(q_valid),
		.cmd_kind(b_kind), .cmd_ovl(b_ovl), .cmd_len(b_len),
		.cmd_bucket(b_bkt), .cmd_text(b_text),
		.pop(pop), .init(init), .done(done), .result(result)
	);

endmodule

>>> hdl/cwh_front.sv
// front end: collects word bytes, keeps the running hash, queues word and clear commands
`timescale 1ns / 1ps
module cwh_front #(
	parameter int BUCKETS      = 1024,
	parameter int MAX_WORD_LEN = 45,
	localparam int BKT_W  = $clog2(BUCKETS),
	localparam int TEXT_W = MAX_WORD_LEN * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                hold,
	input  cwh_pkg::in_item_t   item,
	output logic                busy,
	output logic                push,
	input  logic                full,
	output logic [1:0]          cmd_kind,
	output logic                cmd_ovl,
	output logic [5:0]          cmd_len,
	output logic [BKT_W-1:0]    cmd_bucket,
	output logic [TEXT_W-1:0]   cmd_text
);
	import cwh_pkg::*;

	localparam logic [23:0] BKT_RCP = 24'((32'd1 << 24) / BUCKETS);
	localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_WORD_LEN);

	fstate_t              state_q, state_d;
	logic [1:0]           kind_q;
	logic                 last_q;
	logic [LEN_W-1:0]     cnt_q;
	logic                 ovl_q;
	logic [23:0]          hash_q;
	logic [TEXT_W-1:0]    text_q;
	logic [23:0]          t_q;
	logic [30:0]          x_q;
	logic [47:0]          p_q;
	logic [47:0]          pb_q;
	logic [BKT_W-1:0]     bucket_q;
	logic                 take;
	logic                 is_word;
	logic [31:0]          qm, r32, red;
	logic [47:0]          qbm, rb, rb2;

	assign take    = start & ~busy;
	assign is_word = (item.kind == KIND_INSERT) || (item.kind == KIND_LOOKUP);

	// mod 10000007 and mod BUCKETS by reciprocal, estimate is low by at most one
	always_comb begin
		qm  = 32'(p_q[47:40]) * 32'(HASH_MOD);
		r32 = 32'(x_q) - qm;
		red = (r32 >= 32'(HASH_MOD)) ? r32 - 32'(HASH_MOD) : r32;
		qbm = 48'(pb_q[47:24]) * 48'(BUCKETS);
		rb  = 48'(hash_q) - qbm;
		rb2 = (rb >= 48'(BUCKETS)) ? rb - 48'(BUCKETS) : rb;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FS_IDLE: begin
				if (take) begin
					if (item.kind == KIND_CLEAR) state_d = FS_PUSH;
					else if (is_word) begin
						if (cnt_q < MAX_L) state_d = FS_MUL;
						else if (item.last) state_d = FS_PUSH;
					end
				end
			end
			FS_MUL:  state_d = FS_RCP;
			FS_RCP:  state_d = FS_RED;
			FS_RED:  state_d = last_q ? FS_BMUL : FS_IDLE;
			FS_BMUL: state_d = FS_BRED;
			FS_BRED: state_d = FS_PUSH;
			FS_PUSH: state_d = full ? FS_PUSH : FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != FS_IDLE) | hold;
		push = (state_q == FS_PUSH) & ~full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q   <= '0;
			ovl_q   <= 1'b0;
			hash_q  <= '0;
			text_q  <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				FS_IDLE: begin
					if (take && item.kind == KIND_CLEAR) begin
						cnt_q  <= '0;
						ovl_q  <= 1'b0;
						hash_q <= '0;
						text_q <= '0;
					end else if (take && is_word) begin
						if (cnt_q < MAX_L) begin
							for (int i = 0; i < MAX_WORD_LEN; i++) begin
								if (cnt_q == LEN_W'(i)) text_q[i*8 +: 8] <= item.char_code;
							end
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovl_q <= 1'b1;
						end
					end
				end
				FS_RED: hash_q <= red[23:0];
				FS_PUSH: begin
					if (!full) begin
						cnt_q  <= '0;
						ovl_q  <= 1'b0;
						hash_q <= '0;
						text_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && take) begin
			kind_q <= item.kind;
			last_q <= item.last;
			t_q    <= hash_q + 24'(fold(item.char_code));
		end
		x_q  <= 31'(t_q * 31'(HASH_MUL));
		p_q  <= 48'(x_q) * 48'(HASH_RCP);
		pb_q <= 48'(hash_q) * 48'(BKT_RCP);
		if (state_q == FS_BRED) bucket_q <= rb2[BKT_W-1:0];
	end

	assign cmd_kind   = kind_q;
	assign cmd_ovl    = ovl_q;
	assign cmd_len    = cnt_q;
	assign cmd_bucket = bucket_q;
	assign cmd_text   = text_q;

endmodule

>>> hdl/cwh_queue.sv
// short register queue between front and back end
`timescale 1ns / 1ps
module cwh_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] dout
);
	import cwh_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;
	assign dout    = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= din;
	end

endmodule

>>> hdl/cwh_back.sv
// back end: bucket heads, entry pool, chain walks for insert and lookup, clear sweep
`timescale 1ns / 1ps
module cwh_back #(
	parameter int BUCKETS      = 1024,
	parameter int MAX_WORD_LEN = 45,
	parameter int POOL_ENTRIES = 4096,
	localparam int BKT_W  = $clog2(BUCKETS),
	localparam int TEXT_W = MAX_WORD_LEN * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic [1:0]          cmd_kind,
	input  logic                cmd_ovl,
	input  logic [5:0]          cmd_len,
	input  logic [BKT_W-1:0]    cmd_bucket,
	input  logic [TEXT_W-1:0]   cmd_text,
	output logic                pop,
	output logic                init,
	output logic                done,
	output cwh_pkg::out_item_t  result
);
	import cwh_pkg::*;

	localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);
	localparam int IDX_W  = $clog2(POOL_ENTRIES);
	localparam int DATA_W = TEXT_W + LEN_W;

	logic [CNT_W-1:0]  head_mem [BUCKETS];
	logic [CNT_W-1:0]  link_mem [POOL_ENTRIES];
	logic [DATA_W-1:0] data_mem [POOL_ENTRIES];

	bstate_t           state_q, state_d;
	logic [BKT_W-1:0]  sweep_q, sweep_d;
	logic [CNT_W-1:0]  count_q, cnt_d;
	logic [IDX_W-1:0]  ptr_q, ptr_d;
	logic [1:0]        cmd_kind_q;
	logic              cmd_ovl_q;
	logic [LEN_W-1:0]  cmd_len_q;
	logic [BKT_W-1:0]  cmd_bkt_q;
	logic [TEXT_W-1:0] cmd_text_q;
	logic [CNT_W-1:0]  head_rd_q, link_rd_q;
	logic [DATA_W-1:0] data_rd_q;
	logic              done_q;
	out_item_t         res_q;

	logic              emit, e_found;
	logic [1:0]        e_status;
	logic              head_we, link_we, data_we;
	logic [BKT_W-1:0]  head_wa;
	logic [CNT_W-1:0]  head_wd, link_wd;
	logic [IDX_W-1:0]  link_wa, rd_idx, new_idx;
	logic [CNT_W-1:0]  head_m1, link_m1;
	logic              pool_full, sweep_last, match;
	logic [MAX_WORD_LEN-1:0] byte_ok;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

	assign pool_full  = (count_q == CNT_W'(POOL_ENTRIES));
	assign sweep_last = (sweep_q == BKT_W'(BUCKETS - 1));
	assign new_idx    = count_q[IDX_W-1:0];
	assign head_m1    = head_rd_q - 1'b1;
	assign link_m1    = link_rd_q - 1'b1;

	// case-folded compare of the probed entry against the queued word
	always_comb begin
		for (int i = 0; i < MAX_WORD_LEN; i++) begin
			byte_ok[i] = (LEN_W'(i) >= cmd_len_q) ||
				(fold(data_rd_q[i*8 +: 8]) == fold(cmd_text_q[i*8 +: 8]));
		end
		match = (data_rd_q[TEXT_W +: LEN_W] == cmd_len_q) && (&byte_ok);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_INIT:  if (sweep_last) state_d = BS_IDLE;
			BS_IDLE:  if (cmd_valid) state_d = BS_HEAD;
			BS_HEAD: begin
				if (cmd_kind_q == KIND_CLEAR) state_d = BS_CLEAR;
				else if (cmd_ovl_q || (cmd_kind_q == KIND_INSERT && pool_full)) state_d = BS_IDLE;
				else state_d = BS_HCHK;
			end
			BS_HCHK: begin
				if (head_rd_q == '0) state_d = BS_IDLE;
				else state_d = (cmd_kind_q == KIND_INSERT) ? BS_TAIL : BS_CMP;
			end
			BS_TAIL:  if (link_rd_q == '0) state_d = BS_IDLE;
			BS_CMP:   if (match || link_rd_q == '0) state_d = BS_IDLE;
			BS_CLEAR: if (sweep_last) state_d = BS_IDLE;
			default:  state_d = BS_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		emit     = 1'b0;
		e_found  = 1'b0;
		e_status = ST_OK;
		head_we  = 1'b0;
		head_wa  = cmd_bkt_q;
		head_wd  = count_q + 1'b1;
		link_we  = 1'b0;
		link_wa  = ptr_q;
		link_wd  = count_q + 1'b1;
		data_we  = 1'b0;
		rd_idx   = ptr_q;
		ptr_d    = ptr_q;
		cnt_d    = count_q;
		sweep_d  = sweep_q;
		unique case (state_q)
			BS_INIT, BS_CLEAR: begin
				head_we = 1'b1;
				head_wa = sweep_q;
				head_wd = '0;
				sweep_d = sweep_last ? '0 : sweep_q + 1'b1;
				if (state_q == BS_CLEAR && sweep_last) begin
					emit  = 1'b1;
					cnt_d = '0;
				end
			end
			BS_IDLE: pop = cmd_valid;
			BS_HEAD: begin
				if (cmd_kind_q == KIND_CLEAR) begin
				end else if (cmd_ovl_q) begin
					emit     = 1'b1;
					e_status = ST_TOO_LONG;
				end else if (cmd_kind_q == KIND_INSERT && pool_full) begin
					emit     = 1'b1;
					e_status = ST_POOL_FULL;
				end else if (cmd_kind_q == KIND_INSERT) begin
					// new entry goes in now, linked later as bucket head or at the chain tail
					data_we = 1'b1;
					link_we = 1'b1;
					link_wa = new_idx;
					link_wd = '0;
				end
			end
			BS_HCHK: begin
				if (head_rd_q == '0) begin
					emit = 1'b1;
					if (cmd_kind_q == KIND_INSERT) begin
						head_we = 1'b1;
						cnt_d   = count_q + 1'b1;
					end
				end else begin
					rd_idx = head_m1[IDX_W-1:0];
					ptr_d  = head_m1[IDX_W-1:0];
				end
			end
			BS_TAIL: begin
				if (link_rd_q == '0) begin
					link_we = 1'b1;
					cnt_d   = count_q + 1'b1;
					emit    = 1'b1;
				end else begin
					rd_idx = link_m1[IDX_W-1:0];
					ptr_d  = link_m1[IDX_W-1:0];
				end
			end
			BS_CMP: begin
				if (match) begin
					emit    = 1'b1;
					e_found = 1'b1;
				end else if (link_rd_q == '0) begin
					emit = 1'b1;
				end else begin
					rd_idx = link_m1[IDX_W-1:0];
					ptr_d  = link_m1[IDX_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_INIT;
			sweep_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			count_q <= cnt_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (pop) begin
			cmd_kind_q <= cmd_kind;
			cmd_ovl_q  <= cmd_ovl;
			cmd_len_q  <= cmd_len;
			cmd_bkt_q  <= cmd_bucket;
			cmd_text_q <= cmd_text;
		end
		if (emit) begin
			res_q.found      <= e_found;
			res_q.status     <= e_status;
			res_q.word_count <= cnt_ext[COUNT_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		head_rd_q <= head_mem[cmd_bkt_q];
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[link_wa] <= link_wd;
		link_rd_q <= link_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (data_we) data_mem[new_idx] <= {cmd_len_q, cmd_text_q};
		data_rd_q <= data_mem[rd_idx];
	end

	assign init   = (state_q == BS_INIT);
	assign done   = done_q;
	assign result = res_q;

	a_no_emit_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BS_INIT) |-> !emit) else $error("result during reset sweep");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(POOL_ENTRIES)) else $error("pool count overrun");
	a_pop_to_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == BS_HEAD)) else $error("popped command not started");
	a_found_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.found) |-> ($past(cmd_kind_q) == KIND_LOOKUP))
		else $error("found flagged on a non-lookup");
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && $past(state_q == BS_CLEAR)) |-> (res_q.word_count == '0))
		else $error("clear left a nonzero count");

endmodule

>>> tb/tb.sv
// testbench for the case-insensitive word hash set: scoreboard class and stimulus
`timescale 1ns / 1ps
module tb;
	import cwh_pkg::*;

	localparam int NBKT = 1024;
	localparam int MAXLEN = 45;
	localparam int NPOOL = 4096;

	typedef logic [7:0] word_t [MAXLEN];

	class word_set_scoreboard;
		int unsigned bkt_head [NBKT];
		word_t ent_text [NPOOL];
		int unsigned ent_len [NPOOL];
		int unsigned ent_link [NPOOL];
		word_t cur_word;
		int unsigned cur_len;
		bit cur_over;
		longint unsigned cur_hash;
		int unsigned next_free;
		int unsigned n_words;
		out_item_t pending [$];
		int errors;
		int n_checked;
		int n_found;
		int n_full;
		int n_long;

		function new();
			errors = 0;
			n_checked = 0;
			n_found = 0;
			n_full = 0;
			n_long = 0;
			foreach (bkt_head[i]) bkt_head[i] = 0;
			next_free = 0;
			n_words = 0;
			drop_word();
		endfunction

		function logic [7:0] lower(logic [7:0] c);
			return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
		endfunction

		function void drop_word();
			foreach (cur_word[i]) cur_word[i] = 0;
			cur_len = 0;
			cur_over = 0;
			cur_hash = 0;
		endfunction

		function bit same_word(int unsigned e);
			if (ent_len[e] != cur_len) return 0;
			for (int i = 0; i < cur_len; i++)
				if (lower(ent_text[e][i]) != lower(cur_word[i])) return 0;
			return 1;
		endfunction

		// called for every accepted transfer on the input side
		function void note_input(in_item_t it);
			out_item_t r;
			int unsigned b;
			int unsigned p;
			r = '0;
			if (it.kind == 2'd3) return;
			if (it.kind == KIND_CLEAR) begin
				foreach (bkt_head[i]) bkt_head[i] = 0;
				next_free = 0;
				n_words = 0;
				drop_word();
			end else begin
				if (cur_len < MAXLEN) begin
					cur_word[cur_len] = it.char_code;
					cur_len++;
					cur_hash = ((cur_hash + lower(it.char_code)) * 113) % 10000007;
				end else begin
					cur_over = 1;
				end
				if (!it.last) return;
				b = cur_hash % NBKT;
				if (cur_over) begin
					r.status = ST_TOO_LONG;
				end else if (it.kind == KIND_INSERT) begin
					if (next_free >= NPOOL) begin
						r.status = ST_POOL_FULL;
					end else begin
						ent_text[next_free] = cur_word;
						ent_len[next_free] = cur_len;
						ent_link[next_free] = 0;
						if (bkt_head[b] == 0) begin
							bkt_head[b] = next_free + 1;
						end else begin
							p = bkt_head[b] - 1;
							while (ent_link[p] != 0) p = ent_link[p] - 1;
							ent_link[p] = next_free + 1;
						end
						next_free++;
						n_words++;
					end
				end else begin
					p = bkt_head[b];
					while (p != 0) begin
						if (same_word(p - 1)) begin
							r.found = 1;
							break;
						end
						p = ent_link[p - 1];
					end
				end
				drop_word();
			end
			r.word_count = n_words[12:0];
			pending.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			n_checked++;
			if (exp.found) n_found++;
			if (exp.status == ST_POOL_FULL) n_full++;
			if (exp.status == ST_TOO_LONG) n_long++;
			if (got.found !== exp.found) begin
				$error("found: expected %0d, got %0d", exp.found, got.found);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.word_count !== exp.word_count) begin
				$error("word_count: expected %0d, got %0d", exp.word_count, got.word_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic done;
	out_item_t result;

	word_set_scoreboard sb;
	int idle_pct;
	int n_sent;
	string known_words [$];

	case_insensitive_word_hash_set u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#500ms;
		$display("case_insensitive_word_hash_set: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	// one transfer, with a random idle gap first; start stays high after
	// the transfer until the next send or drain drives it
	task automatic send(logic [1:0] k, logic [7:0] c, logic l);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= '{kind: k, char_code: c, last: l};
		do @(posedge clk); while (busy);
		sb.note_input('{kind: k, char_code: c, last: l});
		n_sent++;
	endtask

	task automatic send_word(logic [1:0] k, string w);
		for (int i = 0; i < w.len(); i++) send(k, w[i], i == w.len() - 1);
	endtask

	function automatic string rand_word(int len);
		string s;
		s = "";
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(3))
				0: s = {s, byte'($urandom_range(65, 90))};
				1, 2: s = {s, byte'($urandom_range(97, 122))};
				default: s = {s, byte'($urandom_range(1, 255))};
			endcase
		end
		return s;
	endfunction

	// flip letter case at random
	function automatic string recase(string w);
		string s;
		s = w;
		for (int i = 0; i < s.len(); i++)
			if ($urandom_range(1) && ((s[i] >= "a" && s[i] <= "z") || (s[i] >= "A" && s[i] <= "Z")))
				s[i] = s[i] ^ 8'h20;
		return s;
	endfunction

	task automatic random_phase(int n);
		string w;
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 40 || known_words.size() == 0) begin
				w = rand_word($urandom_range(1, 8));
				known_words.push_back(w);
				send_word(KIND_INSERT, w);
			end else if (r < 70) begin
				send_word(KIND_LOOKUP, recase(known_words[$urandom_range(known_words.size() - 1)]));
			end else if (r < 85) begin
				send_word(KIND_LOOKUP, rand_word($urandom_range(1, 6)));
			end else if (r < 90) begin
				send_word($urandom_range(1) ? KIND_INSERT : KIND_LOOKUP,
					rand_word($urandom_range(44, 50)));
			end else if (r < 95) begin
				send(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (r < 97) begin
				send(2'd3, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				send(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
				known_words.delete();
			end
		end
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		start <= 0;
		while (sb.pending.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (NBKT + 50) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		start = 0;
		item = '0;
		idle_pct = 0;
		n_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// directed: case folding, odd bytes, overlong, mixed kinds, clears
		send_word(KIND_INSERT, "Hello");
		send_word(KIND_LOOKUP, "hELLO");
		send_word(KIND_LOOKUP, "hell");
		send_word(KIND_INSERT, "hello");
		send(KIND_INSERT, 8'h00, 1'b1);
		send(KIND_LOOKUP, 8'h00, 1'b1);
		send(KIND_LOOKUP, 8'hFF, 1'b1);
		send(KIND_INSERT, 8'hFF, 1'b0);
		send(KIND_LOOKUP, "@", 1'b0);
		send(KIND_INSERT, "[", 1'b1);
		send(KIND_LOOKUP, 8'hFF, 1'b0);
		send(KIND_LOOKUP, "@", 1'b0);
		send(KIND_LOOKUP, "[", 1'b1);
		send_word(KIND_INSERT, rand_word(45));
		send_word(KIND_INSERT, rand_word(46));
		send(2'd3, 8'hAA, 1'b1);
		send(KIND_INSERT, "z", 1'b0);
		send(KIND_CLEAR, 8'h55, 1'b0);
		send(KIND_LOOKUP, "z", 1'b1);
		send_word(KIND_LOOKUP, "hello");
		drain();

		idle_pct = 0;  random_phase(70); drain();
		idle_pct = 54; random_phase(70); drain();
		idle_pct = 0;  random_phase(70); drain();
		idle_pct = 24; random_phase(70); drain();

		$display("sent %0d transfers, checked %0d results: %0d found, %0d pool full, %0d overlong",
			n_sent, sb.n_checked, sb.n_found, sb.n_full, sb.n_long);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("case_insensitive_word_hash_set: match");
		end else begin
			$display("case_insensitive_word_hash_set: mismatch");
		end
		$finish;
	end
endmodule

>>> sim.f
hdl/cwh_pkg.sv
hdl/cwh_front.sv
hdl/cwh_queue.sv
hdl/cwh_back.sv
hdl/case_insensitive_word_hash_set.sv
tb/tb.sv
